// File: sv/nps_pkg.sv
package nps_pkg;

  localparam int POINTS     = 64;
  localparam int COORD_BITS = 20;
  localparam int COORD_DIMS = 3;

  localparam int PORT_COORD_W = 20;
  localparam int PORT_IDX_W   = 6;
  localparam int PORT_DIST_W  = 42;
  localparam int CFG_W        = 7;

  localparam int IDX_W   = $clog2(POINTS);
  localparam int CNT_W   = $clog2(POINTS + 1);
  localparam int ENTRY_W = COORD_DIMS * COORD_BITS;
  localparam int DIST_W  = 2 * COORD_BITS + 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } nps_op_e;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             q_load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_first;
    logic             rd_last;
    logic             out_load;
  } nps_cmd_t;

  typedef struct packed {
    logic scan_done;
  } nps_status_t;

  function automatic logic [COORD_BITS-1:0] coord_take(input logic [PORT_COORD_W-1:0] v);
    logic [COORD_BITS-1:0] r;
    r = '0;
    for (int b = 0; b < COORD_BITS; b++) begin
      if (b < PORT_COORD_W) begin
        r[b] = v[b];
      end
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] idx_from_port(input logic [PORT_IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int b = 0; b < IDX_W; b++) begin
      if (b < PORT_IDX_W) begin
        r[b] = v[b];
      end
    end
    return r;
  endfunction

  function automatic logic [PORT_IDX_W-1:0] idx_to_port(input logic [IDX_W-1:0] v);
    logic [PORT_IDX_W-1:0] r;
    r = '0;
    for (int b = 0; b < PORT_IDX_W; b++) begin
      if (b < IDX_W) begin
        r[b] = v[b];
      end
    end
    return r;
  endfunction

  // saturates to all ones when the exact distance does not fit the port
  function automatic logic [PORT_DIST_W-1:0] dist_to_port(input logic [DIST_W-1:0] v);
    logic [PORT_DIST_W-1:0] r;
    logic                   ovf;
    r   = '0;
    ovf = 1'b0;
    for (int b = 0; b < DIST_W; b++) begin
      if (b < PORT_DIST_W) begin
        r[b] = v[b];
      end else if (v[b]) begin
        ovf = 1'b1;
      end
    end
    if (ovf) begin
      r = '1;
    end
    return r;
  endfunction

endpackage

// File: sv/nps_ctrl.sv
module nps_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [nps_pkg::PORT_IDX_W-1:0]   point_index_i,
  input  logic                             cfg_valid_i,
  input  logic [nps_pkg::CFG_W-1:0]        cfg_point_count_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output nps_pkg::nps_cmd_t                cmd_o,
  input  nps_pkg::nps_status_t             status_i
);
  import nps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_OUT
  } state_e;

  state_e           state_q;
  logic [CFG_W-1:0] count_q;
  logic [IDX_W-1:0] k_q;
  logic [IDX_W-1:0] last_q;
  logic             out_valid_q;

  logic [CNT_W-1:0] n_eff;
  logic             in_beat;
  logic             wr_ok;
  logic             out_free;

  always_comb begin
    priority if (count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(count_q) > 32'(POINTS)) begin
      n_eff = CNT_W'(POINTS);
    end else begin
      n_eff = CNT_W'(count_q);
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_beat     = in_valid_i && in_ready_o;
  assign wr_ok       = 32'(point_index_i) < 32'(POINTS);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.wr_en    = in_beat && (op_i == OP_LOAD) && wr_ok;
    cmd_o.wr_addr  = idx_from_port(point_index_i);
    cmd_o.q_load   = in_beat && (op_i == OP_QUERY);
    cmd_o.rd_en    = (state_q == S_SCAN);
    cmd_o.rd_addr  = k_q;
    cmd_o.rd_first = (k_q == '0);
    cmd_o.rd_last  = (k_q == last_q);
    cmd_o.out_load = (state_q == S_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CFG_W'(1);
      k_q         <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        count_q <= cfg_point_count_i;
      end
      if (out_valid_q && out_ready_i && !cmd_o.out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_beat && (op_i == OP_QUERY)) begin
            k_q     <= '0;
            last_q  <= IDX_W'(n_eff - CNT_W'(1));
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (k_q == last_q) begin
            state_q <= S_WAIT;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        S_WAIT: begin
          if (status_i.scan_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/nps_datapath.sv
module nps_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [nps_pkg::PORT_COORD_W-1:0]  coord_x_i,
  input  logic [nps_pkg::PORT_COORD_W-1:0]  coord_y_i,
  input  logic [nps_pkg::PORT_COORD_W-1:0]  coord_z_i,
  input  nps_pkg::nps_cmd_t                 cmd_i,
  output nps_pkg::nps_status_t              status_o,
  output logic [nps_pkg::PORT_IDX_W-1:0]    best_index_o,
  output logic [nps_pkg::PORT_DIST_W-1:0]   best_distance_o
);
  import nps_pkg::*;

  logic [COORD_BITS-1:0] in_c [3];
  logic [ENTRY_W-1:0]    wr_data;

  logic [ENTRY_W-1:0]    mem_q [POINTS];
  logic [COORD_BITS-1:0] qry_q [COORD_DIMS];

  // stage 1: store read
  logic [ENTRY_W-1:0]    rdata_q;
  logic                  v1_q, first1_q, last1_q;
  logic [IDX_W-1:0]      idx1_q;
  // stage 2: squares
  logic [DIST_W-1:0]     sq_q [COORD_DIMS];
  logic [DIST_W-1:0]     sq_d [COORD_DIMS];
  logic                  v2_q, first2_q, last2_q;
  logic [IDX_W-1:0]      idx2_q;
  // stage 3: sum
  logic [DIST_W-1:0]     sum_q, sum_d;
  logic                  v3_q, first3_q, last3_q;
  logic [IDX_W-1:0]      idx3_q;
  // running best
  logic [DIST_W-1:0]     best_d_q;
  logic [IDX_W-1:0]      best_idx_q;

  logic [PORT_IDX_W-1:0]  out_idx_q;
  logic [PORT_DIST_W-1:0] out_dist_q;

  assign in_c[0] = coord_take(coord_x_i);
  assign in_c[1] = coord_take(coord_y_i);
  assign in_c[2] = coord_take(coord_z_i);

  always_comb begin
    wr_data = '0;
    for (int d = 0; d < COORD_DIMS; d++) begin
      wr_data[d*COORD_BITS +: COORD_BITS] = in_c[d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load) begin
      for (int d = 0; d < COORD_DIMS; d++) begin
        qry_q[d] <= in_c[d];
      end
    end
  end

  always_comb begin
    logic signed [COORD_BITS:0] diff;
    logic        [COORD_BITS:0] mag;
    logic        [COORD_BITS-1:0] rc;
    for (int d = 0; d < COORD_DIMS; d++) begin
      rc   = rdata_q[d*COORD_BITS +: COORD_BITS];
      diff = $signed({qry_q[d][COORD_BITS-1], qry_q[d]}) - $signed({rc[COORD_BITS-1], rc});
      mag  = diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : (COORD_BITS+1)'(diff);
      sq_d[d] = DIST_W'(mag) * DIST_W'(mag);
    end
  end

  always_comb begin
    sum_d = '0;
    for (int d = 0; d < COORD_DIMS; d++) begin
      sum_d = sum_d + sq_q[d];
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q   <= cmd_i.rd_addr;
    first1_q <= cmd_i.rd_first;
    last1_q  <= cmd_i.rd_last;
    idx2_q   <= idx1_q;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    idx3_q   <= idx2_q;
    first3_q <= first2_q;
    last3_q  <= last2_q;
    for (int d = 0; d < COORD_DIMS; d++) begin
      sq_q[d] <= sq_d[d];
    end
    sum_q <= sum_d;
    if (v3_q && (first3_q || (sum_q < best_d_q))) begin
      best_d_q   <= sum_q;
      best_idx_q <= idx3_q;
    end
    if (cmd_i.out_load) begin
      out_idx_q  <= idx_to_port(best_idx_q);
      out_dist_q <= dist_to_port(best_d_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign status_o.scan_done = v3_q && last3_q;
  assign best_index_o       = out_idx_q;
  assign best_distance_o    = out_dist_q;

endmodule

// File: sv/nearest_point_search.sv
// channel  dir  handshake                  payload
// in       in   in_valid_i / in_ready_o    op_i, point_index_i, coord_x_i, coord_y_i, coord_z_i
// out      out  out_valid_o / out_ready_i  best_index_o, best_distance_o
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_point_count_i
//
// A load beat writes the store and leaves input ready high. A query reads point_count
// entries (point_count clamped to 1..64), one store entry a cycle from the single
// read port, then runs a three-stage square, sum and compare pipe and the output load.
// Input ready stays low from a query beat until its result is posted.
// Reset clears control state and sets point_count to 1; the store is not cleared.
// A posted result is held in the output register until taken; a new beat is
// accepted meanwhile, and a finished query waits for the output register to free.
module nearest_point_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [nps_pkg::PORT_IDX_W-1:0]    point_index_i,
  input  logic [nps_pkg::PORT_COORD_W-1:0]  coord_x_i,
  input  logic [nps_pkg::PORT_COORD_W-1:0]  coord_y_i,
  input  logic [nps_pkg::PORT_COORD_W-1:0]  coord_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nps_pkg::PORT_IDX_W-1:0]    best_index_o,
  output logic [nps_pkg::PORT_DIST_W-1:0]   best_distance_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [nps_pkg::CFG_W-1:0]         cfg_point_count_i
);
  import nps_pkg::*;

  nps_cmd_t    cmd;
  nps_status_t status;

  assign cfg_ready_o = 1'b1;

  nps_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .point_index_i     (point_index_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_point_count_i (cfg_point_count_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .cmd_o             (cmd),
    .status_i          (status)
  );

  nps_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .best_index_o    (best_index_o),
    .best_distance_o (best_distance_o)
  );

endmodule

// File: sv/nps_checker.sv
module nps_props (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  logic                              op_i,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic [nps_pkg::PORT_IDX_W-1:0]    best_index_o,
  input  logic [nps_pkg::PORT_DIST_W-1:0]   best_distance_o
);
  import nps_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_index_o)
      && $stable(best_distance_o))
    else $error("result beat changed while stalled");

  // a query beat starts a scan
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_QUERY) |=> !in_ready_o)
    else $error("input ready during scan");

  // a load beat leaves input ready high
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_LOAD) |=> in_ready_o)
    else $error("load beat stalled input");

  // a result is posted only at the end of a scan
  a_post_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result posted without scan");

endmodule

bind nearest_point_search nps_props u_nps_props (.*);
